// ===== src/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg: terminal escape stripper definitions
// Parser state codes and the byte values the escape parser matches on.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  typedef enum logic [2:0] {
    ST_TEXT    = 3'd0,
    ST_ESC     = 3'd1,
    ST_CSI     = 3'd2,
    ST_OSC     = 3'd3,
    ST_OSC_ESC = 3'd4,
    ST_STR     = 3'd5,
    ST_STR_ESC = 3'd6
  } parse_state_e;

  typedef logic [7:0] byte_t;

  localparam byte_t B_BS     = 8'h08;
  localparam byte_t B_TAB    = 8'h09;
  localparam byte_t B_LF     = 8'h0a;
  localparam byte_t B_CR     = 8'h0d;
  localparam byte_t B_BEL    = 8'h07;
  localparam byte_t B_ESC    = 8'h1b;
  localparam byte_t B_SPACE  = 8'h20;
  localparam byte_t B_INT_HI = 8'h2f;
  localparam byte_t B_FIN_LO = 8'h40;
  localparam byte_t B_FIN_HI = 8'h7e;
  localparam byte_t B_DEL    = 8'h7f;
  localparam byte_t B_DCS    = 8'h50;
  localparam byte_t B_CSI    = 8'h5b;
  localparam byte_t B_BSLASH = 8'h5c;
  localparam byte_t B_OSC    = 8'h5d;
  localparam byte_t B_PM     = 8'h5e;
  localparam byte_t B_APC    = 8'h5f;

  function automatic logic passes_text(input byte_t b);
    passes_text = (b == B_BS) || (b == B_TAB) || (b == B_LF) || (b == B_CR) ||
                  ((b >= B_SPACE) && (b != B_DEL));
  endfunction

endpackage

`default_nettype wire

// ===== src/terminal_escape_stripper_top.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_stripper_top: ansi escape sequence stripper
// Filters a terminal output byte stream and passes only plain text bytes.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid_i / in_ready_o / in_byte_i carries one raw byte per
//   transfer; output channel out_valid_o / out_ready_i / out_byte_o carries one
//   surviving text byte per transfer. bytes inside escape, csi, osc and
//   dcs/pm/apc sequences, and control bytes other than bs, tab, lf and cr,
//   give no output transfer.
//   path: a kept byte passes the input register, then the result register,
//   before it is offered on the output.
//   throughput: 1 byte per cycle while the output is not stalled, set by
//   the combinational parser step between the input and result registers.
//   reset: rst_ni low clears both register stages and puts the parser in
//   text state.
//   stall: while the result register holds an untaken byte, the input
//   register can still retire dropped bytes; a kept byte waits there, and
//   in_ready_o falls once the input register is full and cannot advance.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_escape_stripper_top (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  tes_pkg::byte_t   in_byte_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output tes_pkg::byte_t   out_byte_o
);
  import tes_pkg::*;

  logic         in_vld_q;
  byte_t        in_byte_q;
  parse_state_e state_q, state_d;
  logic         emit;
  logic         out_vld_q;
  byte_t        out_byte_q;
  logic         out_free;
  logic         s1_move;

  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_move    = in_vld_q && (out_free || !emit);
  assign in_ready_o = !in_vld_q || s1_move;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ESC: begin
        if (in_byte_q == B_CSI) state_d = ST_CSI;
        else if (in_byte_q == B_OSC) state_d = ST_OSC;
        else if (in_byte_q == B_DCS || in_byte_q == B_PM || in_byte_q == B_APC)
          state_d = ST_STR;
        else if (in_byte_q == B_ESC ||
                 (in_byte_q >= B_SPACE && in_byte_q <= B_INT_HI))
          state_d = ST_ESC;
        else state_d = ST_TEXT;
      end
      ST_CSI: begin
        if (in_byte_q >= B_FIN_LO && in_byte_q <= B_FIN_HI) state_d = ST_TEXT;
        else if (in_byte_q == B_ESC) state_d = ST_ESC;
      end
      ST_OSC: begin
        if (in_byte_q == B_BEL) state_d = ST_TEXT;
        else if (in_byte_q == B_ESC) state_d = ST_OSC_ESC;
      end
      ST_OSC_ESC: begin
        if (in_byte_q == B_BSLASH) state_d = ST_TEXT;
        else if (in_byte_q != B_ESC) state_d = ST_OSC;
      end
      ST_STR: begin
        if (in_byte_q == B_ESC) state_d = ST_STR_ESC;
      end
      ST_STR_ESC: begin
        if (in_byte_q == B_BSLASH) state_d = ST_TEXT;
        else if (in_byte_q != B_ESC) state_d = ST_STR;
      end
      default: begin
        if (in_byte_q == B_ESC) state_d = ST_ESC;
        else state_d = ST_TEXT;
      end
    endcase
  end

  // outputs
  always_comb begin
    emit = 1'b0;
    case (state_q)
      ST_ESC, ST_CSI, ST_OSC, ST_OSC_ESC, ST_STR, ST_STR_ESC: emit = 1'b0;
      default: emit = passes_text(in_byte_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= ST_TEXT;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (s1_move) state_q <= state_d;
      if (out_free) out_vld_q <= s1_move && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= in_byte_i;
    if (out_free && s1_move && emit) out_byte_q <= in_byte_q;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

endmodule

`default_nettype wire

// ===== src/tes_checker.sv =====
// ----------------------------------------------------------------------------
// tes_checker: port checks for the terminal escape stripper
// Watches the top level ports and flags output handshake, content and input stall faults.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_ready_o,
  input wire              out_valid_o,
  input wire              out_ready_i,
  input tes_pkg::byte_t   out_byte_o
);
  import tes_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transfer withdrawn");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o))
    else $error("stalled output byte changed");

  a_out_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_byte_o >= B_SPACE && out_byte_o != B_DEL) ||
                     out_byte_o == B_BS || out_byte_o == B_TAB ||
                     out_byte_o == B_LF || out_byte_o == B_CR))
    else $error("filtered byte reached the output");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind terminal_escape_stripper_top tes_checker u_tes_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: terminal escape stripper testbench
// Feeds raw terminal bytes (plain text, csi, osc, dcs/pm/apc strings, short
// escapes and noise) through the valid/ready input, predicts which bytes
// survive the escape parser, and checks every output transfer in order.
// Runs through phases of no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module tb_top;
  import tes_pkg::*;

  localparam int NUM_ITEMS   = 1900;
  localparam int CYCLE_LIMIT = 200000;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  byte_t in_byte_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  byte_t out_byte_o;

  byte_t        raw_bytes[$];
  byte_t        kept_bytes[$];
  parse_state_e parser_st = ST_TEXT;
  int           n_items   = 0;
  int           n_sent    = 0;
  int           n_errors  = 0;
  int           n_cycles  = 0;
  int           stim_phase;
  int           send_idle_pct;
  int           recv_stall_pct;

  terminal_escape_stripper_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  always #4 clk_i = ~clk_i;

  // one parser step; returns 1 when the byte survives as text
  function automatic logic strip_step(input byte_t b);
    logic keep;
    keep = 1'b0;
    case (parser_st)
      ST_ESC: begin
        if (b == B_CSI) parser_st = ST_CSI;
        else if (b == B_OSC) parser_st = ST_OSC;
        else if (b == B_DCS || b == B_PM || b == B_APC) parser_st = ST_STR;
        else if (b != B_ESC && !(b >= B_SPACE && b <= B_INT_HI)) parser_st = ST_TEXT;
      end
      ST_CSI: begin
        if (b >= B_FIN_LO && b <= B_FIN_HI) parser_st = ST_TEXT;
        else if (b == B_ESC) parser_st = ST_ESC;
      end
      ST_OSC: begin
        if (b == B_BEL) parser_st = ST_TEXT;
        else if (b == B_ESC) parser_st = ST_OSC_ESC;
      end
      ST_OSC_ESC: begin
        if (b == B_BSLASH) parser_st = ST_TEXT;
        else if (b != B_ESC) parser_st = ST_OSC;
      end
      ST_STR: begin
        if (b == B_ESC) parser_st = ST_STR_ESC;
      end
      ST_STR_ESC: begin
        if (b == B_BSLASH) parser_st = ST_TEXT;
        else if (b != B_ESC) parser_st = ST_STR;
      end
      default: begin
        if (b == B_ESC) begin
          parser_st = ST_ESC;
        end else begin
          parser_st = ST_TEXT;
          keep = (b >= B_SPACE && b != B_DEL) || b == B_BS || b == B_TAB ||
                 b == B_LF || b == B_CR;
        end
      end
    endcase
    return keep;
  endfunction

  task automatic put(input byte_t b);
    raw_bytes.push_back(b);
  endtask

  always_comb begin
    stim_phase     = (n_items == 0) ? 0 : (n_sent * 4) / n_items;
    send_idle_pct  = (stim_phase == 1) ? 58 : (stim_phase == 3) ? 9 : 0;
    recv_stall_pct = (stim_phase == 2) ? 58 : (stim_phase == 3) ? 9 : 0;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic  next_valid;
    byte_t next_byte;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= '0;
    end else begin
      next_valid = in_valid_i;
      next_byte  = in_byte_i;
      if (in_valid_i && in_ready_o) begin
        if (strip_step(in_byte_i)) kept_bytes.push_back(in_byte_i);
        n_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && raw_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_valid = 1'b1;
        next_byte  = raw_bytes.pop_front();
      end
      in_valid_i <= next_valid;
      in_byte_i  <= next_byte;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    byte_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (kept_bytes.size() == 0) begin
          $error("out_byte: no transfer expected, actual 0x%02h", out_byte_o);
          n_errors++;
        end else begin
          want = kept_bytes.pop_front();
          if (out_byte_o !== want) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want, out_byte_o);
            n_errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int    pick;
    logic  is_osc;
    byte_t b;

    // text extremes and control bytes
    put(8'h00); put(B_BS); put(B_TAB); put(B_LF); put(B_CR); put(B_BEL);
    put(8'h1f); put(B_SPACE); put(B_FIN_HI); put(B_DEL); put(8'h80); put(8'hff);
    // csi restarted by esc, then finished
    put(B_ESC); put(B_CSI); put(8'h31); put(B_ESC); put(B_CSI); put(8'h6d);
    // osc: esc esc stays, other byte returns to osc, bel ends
    put(B_ESC); put(B_OSC); put(B_ESC); put(B_ESC); put(8'h30); put(B_BEL);
    // dcs ended by esc backslash
    put(B_ESC); put(B_DCS); put(B_ESC); put(B_BSLASH);

    while (raw_bytes.size() < NUM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        repeat ($urandom_range(8, 1)) begin
          case ($urandom_range(9))
            0: put(B_BS);
            1: put(B_TAB);
            2: put(B_LF);
            3: put(B_CR);
            4, 5: put(8'($urandom_range(8'hff, 8'h80)));
            default: put(8'($urandom_range(B_FIN_HI, B_SPACE)));
          endcase
        end
      end else if (pick < 60) begin
        put(B_ESC);
        put(B_CSI);
        repeat ($urandom_range(4)) put(8'($urandom_range(8'h3f, 8'h30)));
        if ($urandom_range(3) == 0) put(8'($urandom_range(B_INT_HI, B_SPACE)));
        put(8'($urandom_range(B_FIN_HI, B_FIN_LO)));
      end else if (pick < 78) begin
        is_osc = (pick < 68);
        put(B_ESC);
        if (is_osc) begin
          put(B_OSC);
        end else begin
          case ($urandom_range(2))
            0: put(B_DCS);
            1: put(B_PM);
            default: put(B_APC);
          endcase
        end
        repeat ($urandom_range(6)) put(8'($urandom_range(8'hff, 8'h20)));
        // escape that does not terminate
        if ($urandom_range(4) == 0) begin
          put(B_ESC);
          put(8'($urandom_range(B_CSI, B_SPACE)));
        end
        if (is_osc && $urandom_range(1)) begin
          put(B_BEL);
        end else begin
          put(B_ESC);
          if ($urandom_range(3) == 0) put(B_ESC);
          put(B_BSLASH);
        end
      end else if (pick < 85) begin
        put(B_ESC);
        repeat ($urandom_range(2)) put(8'($urandom_range(B_INT_HI, B_SPACE)));
        if ($urandom_range(1)) b = 8'($urandom_range(8'h4f, 8'h30));
        else b = 8'($urandom_range(8'h7e, 8'h60));
        put(b);
      end else begin
        put(8'($urandom_range(255)));
      end
    end
    n_items = raw_bytes.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (kept_bytes.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
